/* design/qpvt_pkg.sv */
// ----------------------------------------------------------------------------
// qpvt_pkg
// Shared types and constants of the quadrature position/velocity tracker.
// ----------------------------------------------------------------------------
package qpvt_pkg;

    localparam int DataW   = 32;
    localparam int HalfW   = 16;
    localparam int ScaleW  = 10;
    localparam int DvdW    = 41;   // |delta| * 1000 < 2^41
    localparam int ProdW   = DataW + ScaleW;
    localparam int CntW    = 6;
    localparam int InDataW = 72;   // 65 payload bits padded to bytes
    localparam int OutDataW = 64;
    localparam int CfgIdxW = 2;

    localparam logic [ScaleW-1:0] MS_PER_S = ScaleW'(1000);
    localparam logic [CntW-1:0]   DIV_LAST = CntW'(DvdW - 1);

    // request codes
    localparam logic [1:0] REQ_POSITION = 2'd0;
    localparam logic [1:0] REQ_VELOCITY = 2'd1;
    localparam logic [1:0] REQ_RESET    = 2'd2;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_COUNTER_32 = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_START_POS  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_START_TIME = 2'd2;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic sat;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic vel_start;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

/* design/quadrature_position_velocity_tracker.sv */
// ----------------------------------------------------------------------------
// quadrature_position_velocity_tracker
// Extends raw quadrature counter readings to a 32-bit position and
// estimates velocity in counts per second.
// ----------------------------------------------------------------------------
// Position, reset, unused and unchanged-time requests go from accept straight
// to publish; velocity requests pass accept, multiply, 41 one-bit divider
// steps, saturate and publish.
// One request in flight: a new one is taken only once the last is published,
// also while its result waits; publish stalls while the output is still full.
// aresetn (synchronous) clears position, velocity, last reading, timestamp and mode.
// ----------------------------------------------------------------------------
module quadrature_position_velocity_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // raw_count[31:0], time_ms[63:32], clear_position[64], zero pad
    input  logic [qpvt_pkg::InDataW-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // position[31:0], velocity[63:32]
    output logic [qpvt_pkg::OutDataW-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qpvt_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [qpvt_pkg::DataW-1:0]    cfg_data
);
    import qpvt_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    qpvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qpvt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* design/qpvt_ctrl.sv */
// ----------------------------------------------------------------------------
// qpvt_ctrl
// Sequencer: accept, multiply, divide, saturate, publish.
// ----------------------------------------------------------------------------
module qpvt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  qpvt_pkg::status_t status,
    output qpvt_pkg::cmd_t    cmd
);
    import qpvt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SAT  = 5'b01000,
        ST_PUB  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = status.vel_start ? ST_MUL : ST_PUB;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                cmd.sat    = 1'b1;
                state_next = ST_PUB;
            end
            ST_PUB: begin
                // wait for the output register to free up
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/qpvt_datapath.sv */
// ----------------------------------------------------------------------------
// qpvt_datapath
// Tracker state, delta extension, scale multiply, restoring divider,
// saturation and the output register.
// ----------------------------------------------------------------------------
module qpvt_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [qpvt_pkg::InDataW-1:0]       s_tdata,
    input  logic [1:0]                         s_tuser,
    input  logic                               cfg_valid,
    input  logic [qpvt_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [qpvt_pkg::DataW-1:0]         cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [qpvt_pkg::OutDataW-1:0]      m_tdata,
    input  qpvt_pkg::cmd_t                     cmd,
    output qpvt_pkg::status_t                  status
);
    import qpvt_pkg::*;

    logic [DataW-1:0] raw_count, time_ms;
    logic             clear_position;
    logic [1:0]       req_type;

    assign raw_count      = s_tdata[DataW-1:0];
    assign time_ms        = s_tdata[2*DataW-1:DataW];
    assign clear_position = s_tdata[2*DataW];
    assign req_type       = s_tuser;

    logic             mode32_reg, mode32_next;
    logic [DataW-1:0] last_reg, last_next;
    logic [DataW-1:0] pos_reg, pos_next;
    logic [DataW-1:0] vel_reg, vel_next;
    logic [DataW-1:0] ltime_reg, ltime_next;

    // sample: difference, in 16-bit mode masked and sign-extended to 32 bits
    logic [DataW-1:0] diff32, delta, raw_kept;
    logic [HalfW-1:0] diff16;
    always_comb begin
        diff32 = raw_count - last_reg;
        diff16 = raw_count[HalfW-1:0] - last_reg[HalfW-1:0];
        if (mode32_reg) begin
            delta    = diff32;
            raw_kept = raw_count;
        end else begin
            delta    = {{(DataW-HalfW){diff16[HalfW-1]}}, diff16};
            raw_kept = {{(DataW-HalfW){1'b0}}, raw_count[HalfW-1:0]};
        end
    end

    logic time_moved;
    assign time_moved = (time_ms != ltime_reg);

    // divider operands
    logic             neg_reg;
    logic [DataW-1:0] mag_reg;
    logic [DataW-1:0] dt_reg;
    logic [DvdW-1:0]  dvd_reg;
    logic [DataW:0]   rem_reg;
    logic [CntW-1:0]  cnt_reg;

    logic [ProdW-1:0] prod;
    logic [DataW:0]   rem_shift, rem_sub;
    logic             q_bit;
    assign prod      = mag_reg * {{(ProdW-ScaleW){1'b0}}, MS_PER_S};
    assign rem_shift = {rem_reg[DataW-1:0], dvd_reg[DvdW-1]};
    assign rem_sub   = rem_shift - {1'b0, dt_reg};
    assign q_bit     = (rem_shift >= {1'b0, dt_reg});

    // saturate the signed quotient to int32
    localparam logic [DvdW-1:0] PosMax = DvdW'(32'h7FFF_FFFF);
    localparam logic [DvdW-1:0] NegMax = DvdW'(33'h1_0000_0000) >> 1;
    logic [DataW-1:0] sat_value;
    always_comb begin
        if (neg_reg) begin
            sat_value = (dvd_reg > NegMax) ? 32'h8000_0000
                                           : (~dvd_reg[DataW-1:0] + 32'd1);
        end else begin
            sat_value = (dvd_reg > PosMax) ? 32'h7FFF_FFFF : dvd_reg[DataW-1:0];
        end
    end

    always_comb begin
        mode32_next = mode32_reg;
        last_next   = last_reg;
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        ltime_next  = ltime_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_COUNTER_32: mode32_next = cfg_data[0];
                CFG_START_POS:  pos_next    = cfg_data;
                CFG_START_TIME: ltime_next  = cfg_data;
                default: ;
            endcase
        end
        if (cmd.accept) begin
            case (req_type)
                REQ_POSITION: begin
                    last_next = raw_kept;
                    pos_next  = pos_reg + delta;
                end
                REQ_VELOCITY: begin
                    if (time_moved) begin
                        last_next  = raw_kept;
                        pos_next   = pos_reg + delta;
                        ltime_next = time_ms;
                    end
                end
                REQ_RESET: begin
                    last_next = '0;
                    vel_next  = '0;
                    if (clear_position) begin
                        pos_next = '0;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.sat) begin
            vel_next = sat_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode32_reg <= 1'b0;
            last_reg   <= '0;
            pos_reg    <= '0;
            vel_reg    <= '0;
            ltime_reg  <= '0;
        end else begin
            mode32_reg <= mode32_next;
            last_reg   <= last_next;
            pos_reg    <= pos_next;
            vel_reg    <= vel_next;
            ltime_reg  <= ltime_next;
        end
    end

    // divider payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            neg_reg <= delta[DataW-1];
            mag_reg <= delta[DataW-1] ? (~delta + 32'd1) : delta;
            dt_reg  <= time_ms - ltime_reg;
        end
        if (cmd.mul) begin
            dvd_reg <= prod[DvdW-1:0];
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[DvdW-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub : rem_shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.mul) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + CntW'(1);
        end
    end

    // output register
    logic m_valid_reg;
    logic [OutDataW-1:0] m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= {vel_reg, pos_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign status.vel_start = (req_type == REQ_VELOCITY) && time_moved;
    assign status.div_last  = (cnt_reg == DIV_LAST);
    assign status.out_free  = !m_valid_reg || m_tready;

endmodule

/* test/qpvt_tracker_checker.sv */
// ----------------------------------------------------------------------------
// qpvt_tracker_checker
// Watches the request, result and register channels of the quadrature
// tracker, keeps its own copy of the tracker state, predicts position and
// velocity for every accepted request and compares them, in order, with the
// results the block hands out.
// ----------------------------------------------------------------------------
module qpvt_tracker_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [qpvt_pkg::InDataW-1:0]    s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [qpvt_pkg::OutDataW-1:0]   m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [qpvt_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [qpvt_pkg::DataW-1:0]      cfg_data,
    output int                              n_pending,
    output int                              n_errors
);
    import qpvt_pkg::*;

    localparam longint RateMax = 2147483647;
    localparam longint RateMin = -RateMax - 1;

    typedef struct {
        logic [DataW-1:0] position;
        logic [DataW-1:0] velocity;
    } track_result_t;

    logic             wide_counter;
    logic [DataW-1:0] prev_raw;
    logic [DataW-1:0] pos_acc;
    logic [DataW-1:0] vel_now;
    logic [DataW-1:0] prev_ms;

    track_result_t    track_q[$];
    int               fails = 0;

    assign n_errors = fails;

    // Extend one counter reading into the position; returns the signed step.
    task automatic take_reading(input logic [DataW-1:0] raw, output longint step);
        logic [DataW-1:0] diff;
        diff = raw - prev_raw;
        if (wide_counter) begin
            step     = longint'($signed(diff));
            prev_raw = raw;
        end else begin
            step     = longint'($signed(diff[HalfW-1:0]));
            prev_raw = {{(DataW-HalfW){1'b0}}, raw[HalfW-1:0]};
        end
        pos_acc = pos_acc + step[DataW-1:0];
    endtask

    function automatic logic [DataW-1:0] counts_per_s(input longint step,
                                                       input logic [DataW-1:0] dt);
        longint span;
        longint q;
        span = longint'(dt);
        q = (step * 1000) / span;     // truncates toward zero
        if (q > RateMax) q = RateMax;
        if (q < RateMin) q = RateMin;
        return q[DataW-1:0];
    endfunction

    always @(posedge aclk) begin : track
        logic [1:0]       req;
        logic [DataW-1:0] raw;
        logic [DataW-1:0] ms;
        logic             clr;
        longint           step;
        track_result_t    want;
        logic [DataW-1:0] got_pos;
        logic [DataW-1:0] got_vel;

        if (!aresetn) begin
            wide_counter = 1'b0;
            prev_raw     = '0;
            pos_acc      = '0;
            vel_now      = '0;
            prev_ms      = '0;
            track_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COUNTER_32: wide_counter = cfg_data[0];
                    CFG_START_POS:  pos_acc = cfg_data;
                    CFG_START_TIME: prev_ms = cfg_data;
                    default: ;
                endcase
            end

            // results first, so a result can never match a request of the same edge
            if (m_tvalid && m_tready) begin
                got_pos = m_tdata[DataW-1:0];
                got_vel = m_tdata[2*DataW-1:DataW];
                if (track_q.size() == 0) begin
                    $display("%0t: result with no request pending: position %0d velocity %0d",
                             $time, $signed(got_pos), $signed(got_vel));
                    fails++;
                end else begin
                    want = track_q.pop_front();
                    if (got_pos !== want.position) begin
                        $display("%0t: position expected %0d, got %0d",
                                 $time, $signed(want.position), $signed(got_pos));
                        fails++;
                    end
                    if (got_vel !== want.velocity) begin
                        $display("%0t: velocity expected %0d, got %0d",
                                 $time, $signed(want.velocity), $signed(got_vel));
                        fails++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                req = s_tuser;
                raw = s_tdata[DataW-1:0];
                ms  = s_tdata[2*DataW-1:DataW];
                clr = s_tdata[2*DataW];
                case (req)
                    REQ_POSITION: take_reading(raw, step);
                    REQ_VELOCITY: begin
                        // same timestamp: nothing sampled, stored values reported
                        if (ms != prev_ms) begin
                            take_reading(raw, step);
                            vel_now = counts_per_s(step, ms - prev_ms);
                            prev_ms = ms;
                        end
                    end
                    REQ_RESET: begin
                        prev_raw = '0;
                        vel_now  = '0;
                        if (clr) pos_acc = '0;
                    end
                    default: ;
                endcase
                want.position = pos_acc;
                want.velocity = vel_now;
                track_q.push_back(want);
            end
        end
        n_pending <= track_q.size();
    end

endmodule

/* test/quadrature_position_velocity_tracker_tb.sv */
// ----------------------------------------------------------------------------
// quadrature_position_velocity_tracker_tb
// Drives position, velocity, reset and unused requests into the tracker,
// first a directed set around counter wrap, mode change, timestamp wrap and
// velocity saturation, then phases of random encoder-like traffic under
// different register settings, with random idling on both sides and a long
// result stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module quadrature_position_velocity_tracker_tb;

    import qpvt_pkg::*;

    localparam logic [1:0]         REQ_UNUSED = 2'd3;
    localparam logic [CfgIdxW-1:0] CFG_NONE   = 2'd3;
    localparam int HoldCycles  = 200;
    localparam int TailCycles  = 60;
    localparam int PhaseItems  = 100;
    localparam int Phases      = 7;
    localparam int StressPhase = 2;
    localparam int QuietPhase  = 4;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OutDataW-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [DataW-1:0]     cfg_data  = '0;

    int                   n_pending;
    int                   n_errors;

    logic                 tx_idle   = 1'b1;
    logic                 rx_idle   = 1'b1;
    int                   hold_reqs = 0;
    int                   hold_done = 0;
    int                   stall_left = 0;

    // encoder-like stimulus: last reading offered and time of last velocity request
    logic [DataW-1:0]     cur_raw = '0;
    logic [DataW-1:0]     cur_ms  = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    quadrature_position_velocity_tracker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qpvt_tracker_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .n_pending (n_pending),
        .n_errors  (n_errors)
    );

    // result side: random back-pressure plus an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_done  <= 0;
        end else if (hold_done != hold_reqs) begin
            hold_done  <= hold_done + 1;
            stall_left <= HoldCycles;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= !(rx_idle && $urandom_range(99) < 19);
        end
    end

    task automatic send_req(input logic [1:0] req, input logic [DataW-1:0] raw,
                            input logic [DataW-1:0] ms, input logic clr);
        while (tx_idle && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, clr, ms, raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    task automatic send_random_req();
        int               r;
        logic [1:0]       req;
        logic [DataW-1:0] ms;
        logic             clr;
        r   = $urandom_range(99);
        ms  = $urandom;
        clr = 1'($urandom_range(1));
        if (r < 45)      req = REQ_POSITION;
        else if (r < 85) req = REQ_VELOCITY;
        else if (r < 95) req = REQ_RESET;
        else             req = REQ_UNUSED;
        // mostly small moves of the encoder, now and then a jump
        r = $urandom_range(99);
        if (r < 75)      cur_raw = cur_raw + $urandom_range(400) - 200;
        else if (r < 90) cur_raw = cur_raw + $urandom_range(65535) - 32768;
        else             cur_raw = $urandom;
        if (req == REQ_VELOCITY) begin
            r = $urandom_range(99);
            if (r < 10)      ms = cur_ms;
            else if (r < 80) ms = cur_ms + $urandom_range(1, 200);
            else if (r < 92) ms = cur_ms + $urandom_range(1, 3);
            else             ms = $urandom;
            cur_ms = ms;
        end
        send_req(req, cur_raw, ms, clr);
    endtask

    initial begin : stimulus
        int               r;
        logic [DataW-1:0] v;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 16-bit counter: wrap both ways, upper bits ignored
        send_req(REQ_POSITION, 32'h0000_7FFF, 32'h0, 1'b0);
        send_req(REQ_POSITION, 32'h0000_8000, 32'hFFFF_FFFF, 1'b1);
        send_req(REQ_POSITION, 32'hFFFF_0000, 32'h0, 1'b0);
        send_req(REQ_POSITION, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_req(REQ_VELOCITY, 32'h0000_0005, 32'h0, 1'b0);          // same time
        send_req(REQ_VELOCITY, 32'h0000_0005, 32'h1, 1'b0);          // dt of one
        send_req(REQ_UNUSED, $urandom, $urandom, 1'b1);
        send_req(REQ_RESET, 32'h1234_5678, 32'h0, 1'b0);
        send_req(REQ_RESET, 32'h0, 32'h0, 1'b1);
        send_req(REQ_VELOCITY, 32'hFFFF_8000, 32'h1, 1'b0);          // time kept by reset
        send_req(REQ_VELOCITY, 32'h0000_8000, 32'hFFFF_FFFF, 1'b0);  // rounds to zero
        drain();

        write_reg(CFG_COUNTER_32, 32'd1);
        write_reg(CFG_START_POS, 32'h7FFF_FFFF);
        write_reg(CFG_START_TIME, 32'hFFFF_FFF0);
        write_reg(CFG_NONE, $urandom);
        send_req(REQ_POSITION, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_req(REQ_VELOCITY, 32'hFFFF_FFFF, 32'hFFFF_FFF1, 1'b0);  // saturates low
        send_req(REQ_VELOCITY, 32'h7FFF_FFFE, 32'hFFFF_FFF2, 1'b0);  // saturates high
        send_req(REQ_VELOCITY, 32'h7FFF_FFFF, 32'h0000_0010, 1'b0);  // time wraps
        send_req(REQ_RESET, 32'h0, 32'h0, 1'b0);
        send_req(REQ_POSITION, 32'h8000_0000, 32'h0, 1'b0);
        drain();

        // back to 16 bits with upper bits left in the last reading
        write_reg(CFG_COUNTER_32, 32'd0);
        write_reg(CFG_START_POS, 32'h8000_0000);
        send_req(REQ_POSITION, 32'h0000_0001, 32'h0, 1'b0);
        send_req(REQ_VELOCITY, 32'h0001_7FFF, 32'h0000_0020, 1'b0);
        send_req(REQ_POSITION, 32'hABCD_8001, 32'h0, 1'b0);
        drain();

        for (int ph = 0; ph < Phases; ph++) begin
            tx_idle = (ph != QuietPhase);
            rx_idle <= (ph != QuietPhase);
            write_reg(CFG_COUNTER_32, $urandom_range(1));
            r = $urandom_range(99);
            if (r < 25)      v = 32'h7FFF_FFFF;
            else if (r < 50) v = 32'h8000_0000;
            else             v = $urandom;
            write_reg(CFG_START_POS, v);
            r = $urandom_range(99);
            if (r < 30) v = 32'hFFFF_FFFF - $urandom_range(1000);
            else        v = $urandom;
            write_reg(CFG_START_TIME, v);
            cur_ms = v;
            if ($urandom_range(3) == 0) write_reg(CFG_NONE, $urandom);
            // long result stall while requests keep coming
            if (ph == StressPhase) hold_reqs <= hold_reqs + 1;
            repeat (PhaseItems) send_random_req();
            drain();
        end

        repeat (TailCycles) @(posedge aclk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("quadrature_position_velocity_tracker_tb: done, clean");
        end else begin
            $display("quadrature_position_velocity_tracker_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("quadrature_position_velocity_tracker_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
design/qpvt_pkg.sv
design/qpvt_ctrl.sv
design/qpvt_datapath.sv
design/quadrature_position_velocity_tracker.sv
test/qpvt_tracker_checker.sv
test/quadrature_position_velocity_tracker_tb.sv
